[hdl/sasd_pkg.sv]
// Shared types, constants and tables for the stereo arcsine shaper with dither.
// Used by sasd_core and stereo_arcsine_shaper_dither_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sasd_pkg;

    // Sample format: signed, SAMPLE_BITS-1 fraction bits
    localparam int SAMPLE_BITS = 24;
    localparam int OUT_W       = 25;
    localparam int DITHER_W    = 10;

    // Stream bus widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

    // Internal Q32 arithmetic
    localparam int Q_W     = 32;
    localparam int ROOT_W  = 64;
    localparam int SUM_W   = Q_W + 1;
    localparam int MAG_W   = Q_W + 2;
    localparam int VAL_W   = Q_W + 4;
    localparam int DIV_W   = 40;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int REM_W   = 11;
    localparam int NUM_W   = 10;
    localparam int RND_SHIFT = 9;

    localparam logic [MAG_W-1:0] PI_HALF_Q32 = 34'h1921FB544;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sd13176795;
    localparam logic [ROOT_W-1:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic signed [VAL_W-1:0] RND_HALF = 36'sd256;

    // Series of asin: term k+1 = term k * z^2 * NUM[k] / DEN[k]
    localparam int SERIES_TERMS = 16;
    localparam int K_W = $clog2(SERIES_TERMS);
    localparam logic [NUM_W-1:0] SERIES_NUM [SERIES_TERMS] = '{
        10'd1,   10'd9,   10'd25,  10'd49,  10'd81,  10'd121, 10'd169, 10'd225,
        10'd289, 10'd361, 10'd441, 10'd529, 10'd625, 10'd729, 10'd841, 10'd961
    };
    localparam logic [REM_W-1:0] SERIES_DEN [SERIES_TERMS] = '{
        11'd6,   11'd20,  11'd42,  11'd72,  11'd110, 11'd156, 11'd210, 11'd272,
        11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812, 11'd930, 11'd1056
    };

    // Dither generators
    localparam logic [31:0] SEED_LEFT  = 32'h2545F491;
    localparam logic [31:0] SEED_RIGHT = 32'h9E3779B9;
    localparam logic signed [DITHER_W-1:0] DITHER_CENTER = 10'sd255;

    // Request to and response from the per-channel arithmetic core
    typedef struct packed {
        logic                       start;
        logic [SAMPLE_BITS-1:0]     sample;
        logic signed [DITHER_W-1:0] dither;
    } t_core_req;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] result;
    } t_core_rsp;

    // One xorshift32 step, shifts 13, 17, 5
    function automatic logic [31:0] xorshift_step(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    // Dither in Q32 units: top nine bits of the state, centered
    function automatic logic signed [DITHER_W-1:0] dither_of(input logic [31:0] x);
        return $signed({1'b0, x[31:23]}) - DITHER_CENTER;
    endfunction

endpackage

`default_nettype wire

[hdl/sasd_mul.sv]
// Shared 32x32 multiplier with a registered 64-bit product.
// No dependencies; used by sasd_core.
`timescale 1ns / 1ps
`default_nettype none

module sasd_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);

    // Register the product
    always_ff @(posedge i_clk) begin
        o_prod <= i_a * i_b;
    end

endmodule

`default_nettype wire

[hdl/sasd_csub.sv]
// Shared compare-and-subtract unit for the square-root and divide steps.
// No dependencies; used by sasd_core.
`timescale 1ns / 1ps
`default_nettype none

module sasd_csub (
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic      [63:0] o_diff,
    output logic             o_ge
);

    logic borrow;

    // Subtract and flag a >= b
    assign {borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = ~borrow;

endmodule

`default_nettype wire

[hdl/sasd_core.sv]
// Per-channel arcsine with dither and rounding, run by a small sequencer
// over one shared multiplier and one shared compare-subtract unit.
// Depends on sasd_pkg, sasd_mul, sasd_csub.
`timescale 1ns / 1ps
`default_nettype none

module sasd_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sasd_pkg::t_core_req i_req,
    output sasd_pkg::t_core_rsp      o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE, S_ROOT, S_SQR, S_SQRW, S_M1, S_M2, S_DLD, S_DIV, S_ACC, S_FIN, S_RND
    } t_core_state;

    t_core_state r_state;
    logic                                r_neg;
    logic                                r_upper;
    logic [sasd_pkg::Q_W-1:0]            r_z;
    logic [sasd_pkg::ROOT_W-1:0]         r_v;
    logic [sasd_pkg::ROOT_W-1:0]         r_r;
    logic [sasd_pkg::ROOT_W-1:0]         r_bit;
    logic [sasd_pkg::Q_W-1:0]            r_z2;
    logic [sasd_pkg::Q_W-1:0]            r_t;
    logic [sasd_pkg::SUM_W-1:0]          r_s;
    logic [sasd_pkg::K_W-1:0]            r_k;
    logic [sasd_pkg::REM_W-1:0]          r_rem;
    logic [sasd_pkg::DIV_W-1:0]          r_quo;
    logic [sasd_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic signed [sasd_pkg::VAL_W-1:0]   r_val;
    logic signed [sasd_pkg::DITHER_W-1:0] r_dither;
    logic signed [sasd_pkg::OUT_W-1:0]   r_result;
    logic                                r_done;

    logic [63:0] cs_a, cs_b, cs_diff;
    logic        cs_ge;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;

    logic [sasd_pkg::SAMPLE_BITS-1:0] in_abs;
    logic                             in_neg;
    logic                             in_lower;
    logic [32:0]                      z_ext;
    logic [sasd_pkg::SAMPLE_BITS-1:0] in_w;
    logic [sasd_pkg::ROOT_W-1:0]      v_init;
    logic [sasd_pkg::ROOT_W-1:0]      root_nx;
    logic [sasd_pkg::REM_W:0]         div_trial;
    logic [sasd_pkg::MAG_W-1:0]       mag;
    logic signed [sasd_pkg::VAL_W-1:0] mag_s;
    logic signed [sasd_pkg::VAL_W-1:0] rnd_sum;
    logic signed [sasd_pkg::VAL_W-sasd_pkg::RND_SHIFT-1:0] rnd_q;
    logic signed [sasd_pkg::OUT_W-1:0] sat_q;

    sasd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    sasd_csub u_csub (
        .i_a    (cs_a),
        .i_b    (cs_b),
        .o_diff (cs_diff),
        .o_ge   (cs_ge)
    );

    // Decode the incoming sample: magnitude, path and starting operands
    always_comb begin
        in_neg   = i_req.sample[sasd_pkg::SAMPLE_BITS-1];
        in_abs   = in_neg ? (~i_req.sample + 1'b1) : i_req.sample;
        in_lower = in_abs <= (sasd_pkg::SAMPLE_BITS)'(1 << (sasd_pkg::SAMPLE_BITS - 2));
        z_ext    = {in_abs, {(33 - sasd_pkg::SAMPLE_BITS){1'b0}}};
        in_w     = (sasd_pkg::SAMPLE_BITS)'(1 << (sasd_pkg::SAMPLE_BITS - 1)) - in_abs;
        v_init   = {in_w, {(64 - sasd_pkg::SAMPLE_BITS){1'b0}}};
    end

    // Steer the shared units by state
    always_comb begin
        div_trial = {r_rem, r_quo[sasd_pkg::DIV_W-1]};
        root_nx   = cs_ge ? ((r_r >> 1) | r_bit) : (r_r >> 1);
        if (r_state == S_DIV) begin
            cs_a = {{(64 - sasd_pkg::REM_W - 1){1'b0}}, div_trial};
            cs_b = {{(64 - sasd_pkg::REM_W){1'b0}}, sasd_pkg::SERIES_DEN[r_k]};
        end else begin
            cs_a = r_v;
            cs_b = r_r | r_bit;
        end
        case (r_state)
            S_SQR: begin
                mul_a = r_z;
                mul_b = r_z;
            end
            S_M2: begin
                mul_a = mul_prod[63:32];
                mul_b = {{(32 - sasd_pkg::NUM_W){1'b0}}, sasd_pkg::SERIES_NUM[r_k]};
            end
            default: begin
                mul_a = r_t;
                mul_b = r_z2;
            end
        endcase
    end

    // Apply the sign, then add dither and round half up with saturation
    always_comb begin
        mag     = r_upper ? (sasd_pkg::PI_HALF_Q32 - {r_s, 1'b0}) : {1'b0, r_s};
        mag_s   = $signed({2'b00, mag});
        rnd_sum = r_val + sasd_pkg::VAL_W'(r_dither) + sasd_pkg::RND_HALF;
        rnd_q   = rnd_sum[sasd_pkg::VAL_W-1:sasd_pkg::RND_SHIFT];
        if (rnd_q > sasd_pkg::OUT_MAX) begin
            sat_q = sasd_pkg::OUT_MAX;
        end else if (rnd_q < -sasd_pkg::OUT_MAX) begin
            sat_q = -sasd_pkg::OUT_MAX;
        end else begin
            sat_q = rnd_q[sasd_pkg::OUT_W-1:0];
        end
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_neg    <= in_neg;
                        r_upper  <= ~in_lower;
                        r_dither <= i_req.dither;
                        r_z      <= z_ext[31:0];
                        r_v      <= v_init;
                        r_r      <= '0;
                        r_bit    <= sasd_pkg::ROOT_BIT0;
                        r_state  <= in_lower ? S_SQR : S_ROOT;
                    end
                end
                // One root bit per cycle
                S_ROOT: begin
                    if (cs_ge) begin
                        r_v <= cs_diff;
                    end
                    r_r   <= root_nx;
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_z     <= root_nx[31:0];
                        r_state <= S_SQR;
                    end
                end
                S_SQR: begin
                    r_state <= S_SQRW;
                end
                S_SQRW: begin
                    r_z2    <= mul_prod[63:32];
                    r_t     <= r_z;
                    r_s     <= {1'b0, r_z};
                    r_k     <= '0;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_state <= S_DLD;
                end
                S_DLD: begin
                    r_quo   <= mul_prod[sasd_pkg::DIV_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= sasd_pkg::DIV_CNT_W'(sasd_pkg::DIV_W - 1);
                    r_state <= S_DIV;
                end
                // One quotient bit per cycle
                S_DIV: begin
                    r_rem <= cs_ge ? cs_diff[sasd_pkg::REM_W-1:0]
                                   : div_trial[sasd_pkg::REM_W-1:0];
                    r_quo <= {r_quo[sasd_pkg::DIV_W-2:0], cs_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_t <= r_quo[31:0];
                    r_s <= r_s + {1'b0, r_quo[31:0]};
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k == sasd_pkg::K_W'(sasd_pkg::SERIES_TERMS - 1)) ? S_FIN
                                                                                   : S_M1;
                end
                S_FIN: begin
                    r_val   <= r_neg ? -mag_s : mag_s;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_result <= sat_q;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == S_IDLE)
        else $error("core started while busy");

    a_result_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_result <= sasd_pkg::OUT_MAX && r_result >= -sasd_pkg::OUT_MAX))
        else $error("result beyond saturation limit");

    a_root_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ROOT |-> $onehot(r_bit))
        else $error("square root bit lost");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |=> (r_state == S_DIV || r_state == S_ACC))
        else $error("divide loop left early");

endmodule

`default_nettype wire

[hdl/stereo_arcsine_shaper_dither_unit.sv]
// Top level: stream ports, dither generators, channel sequencing, output register.
// Depends on sasd_pkg and sasd_core.
//
//  Channel | Dir | Signals                      | Contents
//  s_axis  | in  | tvalid, tready, tdata[47:0]  | one stereo frame
//  m_axis  | out | tvalid, tready, tdata[55:0]  | one shaped, dithered frame
//
// A frame passes both channels through the core; a channel that exceeds one half
// in magnitude also takes the square-root path before its series.
// Each of the 16 series terms goes through the 40-bit bit-serial divide of the core.
// The channels run one after the other through the single core; s_axis_tready is
// low from acceptance until the result is loaded into the output register.
// The output register holds a result while m_axis stalls; the next frame is
// accepted meanwhile. Reset is synchronous, active low, and reloads the seeds.
`timescale 1ns / 1ps
`default_nettype none

module stereo_arcsine_shaper_dither_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_left [23:0], sample_right [47:24]
    input  wire logic [sasd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // out_left [24:0], out_right [49:25], zero pad above
    output logic [sasd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    typedef enum logic [1:0] {T_IDLE, T_LEFT, T_RIGHT, T_PUSH} t_top_state;

    t_top_state r_state;
    logic [31:0] r_noise_l;
    logic [31:0] r_noise_r;
    sasd_pkg::t_core_req r_core_req;
    sasd_pkg::t_core_rsp core_rsp;
    logic [sasd_pkg::SAMPLE_BITS-1:0]     r_sample_r;
    logic signed [sasd_pkg::DITHER_W-1:0] r_dither_r;
    logic signed [sasd_pkg::OUT_W-1:0]    r_res_l;
    logic signed [sasd_pkg::OUT_W-1:0]    r_res_r;
    logic                                 r_out_valid;
    logic signed [sasd_pkg::OUT_W-1:0]    r_out_l;
    logic signed [sasd_pkg::OUT_W-1:0]    r_out_r;

    logic        in_accept;
    logic [31:0] n_noise_l;
    logic [31:0] n_noise_r;

    sasd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_core_req),
        .o_rsp   (core_rsp)
    );

    // Handshake and next generator states
    assign s_axis_tready = (r_state == T_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign n_noise_l     = sasd_pkg::xorshift_step(r_noise_l);
    assign n_noise_r     = sasd_pkg::xorshift_step(r_noise_r);

    // Sequence the two channels and hand off to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= T_IDLE;
            r_core_req.start <= 1'b0;
            r_out_valid      <= 1'b0;
            r_noise_l        <= sasd_pkg::SEED_LEFT;
            r_noise_r        <= sasd_pkg::SEED_RIGHT;
        end else begin
            r_core_req.start <= 1'b0;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (in_accept) begin
                        r_noise_l         <= n_noise_l;
                        r_noise_r         <= n_noise_r;
                        r_core_req.start  <= 1'b1;
                        r_core_req.sample <= s_axis_tdata[sasd_pkg::SAMPLE_BITS-1:0];
                        r_core_req.dither <= sasd_pkg::dither_of(n_noise_l);
                        r_sample_r <= s_axis_tdata[2*sasd_pkg::SAMPLE_BITS-1:
                                                   sasd_pkg::SAMPLE_BITS];
                        r_dither_r <= sasd_pkg::dither_of(n_noise_r);
                        r_state    <= T_LEFT;
                    end
                end
                T_LEFT: begin
                    if (core_rsp.done) begin
                        r_res_l           <= core_rsp.result;
                        r_core_req.start  <= 1'b1;
                        r_core_req.sample <= r_sample_r;
                        r_core_req.dither <= r_dither_r;
                        r_state           <= T_RIGHT;
                    end
                end
                T_RIGHT: begin
                    if (core_rsp.done) begin
                        r_res_r <= core_rsp.result;
                        r_state <= T_PUSH;
                    end
                end
                T_PUSH: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_l     <= r_res_l;
                        r_out_r     <= r_res_r;
                        r_state     <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(sasd_pkg::OUT_TDATA_W - 2 * sasd_pkg::OUT_W){1'b0}},
                            r_out_r, r_out_l};

    a_accept_starts_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == T_LEFT && r_core_req.start))
        else $error("accepted frame did not start the left channel");

    a_noise_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_l != 32'd0 && r_noise_r != 32'd0)
        else $error("dither generator stuck at zero");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_rsp.done |-> (r_state == T_LEFT || r_state == T_RIGHT))
        else $error("core result with no channel in flight");

endmodule

`default_nettype wire
